@@ rtl/core/clnb_pkg.sv @@
// ----------------------------------------------------------------------------
// clnb_pkg
// Shared types, register map, request codes and the control store for the
// character LCD 4-bit bus sequencer.
// ----------------------------------------------------------------------------
package clnb_pkg;

  // display geometry default
  localparam int ROWS_DEF = 4;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_ENABLE_PULSE = 3'd0,
    REG_SETTLE       = 3'd1,
    REG_LONG_CMD     = 3'd2,
    REG_POWER_WAIT   = 3'd3,
    REG_LINE_LENGTH  = 3'd4
  } clnb_reg_t;

  // register reset values
  localparam logic [7:0]  RST_ENABLE_PULSE = 8'd1;
  localparam logic [9:0]  RST_SETTLE       = 10'd40;
  localparam logic [15:0] RST_LONG_CMD     = 16'd2000;
  localparam logic [15:0] RST_POWER_WAIT   = 16'd50000;
  localparam logic [6:0]  RST_LINE_LENGTH  = 7'd20;

  typedef struct packed {
    logic [7:0]  enable_pulse_us;
    logic [9:0]  settle_us;
    logic [15:0] long_cmd_us;
    logic [15:0] power_wait_us;
    logic [6:0]  line_length;
  } clnb_cfg_t;

  // request codes
  typedef enum logic [1:0] {
    REQ_INIT   = 2'd0,
    REQ_CMD    = 2'd1,
    REQ_DATA   = 2'd2,
    REQ_CURSOR = 2'd3
  } clnb_req_t;

  // lcd command constants
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] ROW1_BASE     = 8'h40;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME_HI   = 8'h03;

  // init settle additions
  localparam logic [15:0] INIT_WAIT_A = 16'd4500;
  localparam logic [15:0] INIT_WAIT_B = 16'd150;

  // control store layout
  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] INIT_ENTRY = 6'd0;
  localparam logic [PC_W-1:0] BYTE_ENTRY = 6'd37;
  localparam logic [PC_W-1:0] PROG_END   = 6'd43;

  typedef enum logic [1:0] {
    NIB_CONST = 2'd0,
    NIB_HELD  = 2'd1,
    NIB_HI    = 2'd2,
    NIB_LO    = 2'd3
  } clnb_nib_t;

  typedef enum logic [2:0] {
    HOLD_POWER       = 3'd0,
    HOLD_PULSE       = 3'd1,
    HOLD_SETTLE      = 3'd2,
    HOLD_SETTLE_A    = 3'd3,
    HOLD_SETTLE_B    = 3'd4,
    HOLD_SETTLE_LONG = 3'd5,
    HOLD_SETTLE_COND = 3'd6
  } clnb_hold_t;

  // one control word per pin state
  typedef struct packed {
    clnb_nib_t  nib_sel;
    logic [3:0] nib;
    logic       en;
    logic       use_rs;
    clnb_hold_t hold_sel;
    logic       last;
  } clnb_cw_t;

  function automatic clnb_cw_t clnb_cw(input clnb_nib_t sel, input logic [3:0] nib,
                                       input logic en, input logic use_rs,
                                       input clnb_hold_t hold, input logic last);
    clnb_cw_t w;
    w.nib_sel  = sel;
    w.nib      = nib;
    w.en       = en;
    w.use_rs   = use_rs;
    w.hold_sel = hold;
    w.last     = last;
    return w;
  endfunction

  // microcode: init run at 0, byte run at 37
  function automatic clnb_cw_t clnb_ucode(input logic [PC_W-1:0] pc);
    clnb_cw_t w;
    case (pc)
      // power wait, data pins keep their level
      6'd0:  w = clnb_cw(NIB_HELD,  4'h0, 1'b0, 1'b0, HOLD_POWER,       1'b0);
      // nibble 3 three times, long settles after the first two
      6'd1:  w = clnb_cw(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_PULSE,       1'b0);
      6'd2:  w = clnb_cw(NIB_CONST, 4'h3, 1'b1, 1'b0, HOLD_PULSE,       1'b0);
      6'd3:  w = clnb_cw(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_SETTLE_A,    1'b0);
      6'd4:  w = clnb_cw(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_PULSE,       1'b0);
      6'd5:  w = clnb_cw(NIB_CONST, 4'h3, 1'b1, 1'b0, HOLD_PULSE,       1'b0);
      6'd6:  w = clnb_cw(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_SETTLE_A,    1'b0);
      6'd7:  w = clnb_cw(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_PULSE,       1'b0);
      6'd8:  w = clnb_cw(NIB_CONST, 4'h3, 1'b1, 1'b0, HOLD_PULSE,       1'b0);
      6'd9:  w = clnb_cw(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_SETTLE_B,    1'b0);
      // switch to 4-bit mode
      6'd10: w = clnb_cw(NIB_CONST, 4'h2, 1'b0, 1'b0, HOLD_PULSE,       1'b0);
      6'd11: w = clnb_cw(NIB_CONST, 4'h2, 1'b1, 1'b0, HOLD_PULSE,       1'b0);
      6'd12: w = clnb_cw(NIB_CONST, 4'h2, 1'b0, 1'b0, HOLD_SETTLE,      1'b0);
      // function set 0x28
      6'd13: w = clnb_cw(NIB_CONST, 4'h2, 1'b0, 1'b0, HOLD_PULSE,       1'b0);
      6'd14: w = clnb_cw(NIB_CONST, 4'h2, 1'b1, 1'b0, HOLD_PULSE,       1'b0);
      6'd15: w = clnb_cw(NIB_CONST, 4'h2, 1'b0, 1'b0, HOLD_SETTLE,      1'b0);
      6'd16: w = clnb_cw(NIB_CONST, 4'h8, 1'b0, 1'b0, HOLD_PULSE,       1'b0);
      6'd17: w = clnb_cw(NIB_CONST, 4'h8, 1'b1, 1'b0, HOLD_PULSE,       1'b0);
      6'd18: w = clnb_cw(NIB_CONST, 4'h8, 1'b0, 1'b0, HOLD_SETTLE,      1'b0);
      // display on 0x0c
      6'd19: w = clnb_cw(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_PULSE,       1'b0);
      6'd20: w = clnb_cw(NIB_CONST, 4'h0, 1'b1, 1'b0, HOLD_PULSE,       1'b0);
      6'd21: w = clnb_cw(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_SETTLE,      1'b0);
      6'd22: w = clnb_cw(NIB_CONST, 4'hC, 1'b0, 1'b0, HOLD_PULSE,       1'b0);
      6'd23: w = clnb_cw(NIB_CONST, 4'hC, 1'b1, 1'b0, HOLD_PULSE,       1'b0);
      6'd24: w = clnb_cw(NIB_CONST, 4'hC, 1'b0, 1'b0, HOLD_SETTLE,      1'b0);
      // clear 0x01 with long wait
      6'd25: w = clnb_cw(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_PULSE,       1'b0);
      6'd26: w = clnb_cw(NIB_CONST, 4'h0, 1'b1, 1'b0, HOLD_PULSE,       1'b0);
      6'd27: w = clnb_cw(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_SETTLE,      1'b0);
      6'd28: w = clnb_cw(NIB_CONST, 4'h1, 1'b0, 1'b0, HOLD_PULSE,       1'b0);
      6'd29: w = clnb_cw(NIB_CONST, 4'h1, 1'b1, 1'b0, HOLD_PULSE,       1'b0);
      6'd30: w = clnb_cw(NIB_CONST, 4'h1, 1'b0, 1'b0, HOLD_SETTLE_LONG, 1'b0);
      // entry mode 0x06
      6'd31: w = clnb_cw(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_PULSE,       1'b0);
      6'd32: w = clnb_cw(NIB_CONST, 4'h0, 1'b1, 1'b0, HOLD_PULSE,       1'b0);
      6'd33: w = clnb_cw(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_SETTLE,      1'b0);
      6'd34: w = clnb_cw(NIB_CONST, 4'h6, 1'b0, 1'b0, HOLD_PULSE,       1'b0);
      6'd35: w = clnb_cw(NIB_CONST, 4'h6, 1'b1, 1'b0, HOLD_PULSE,       1'b0);
      6'd36: w = clnb_cw(NIB_CONST, 4'h6, 1'b0, 1'b0, HOLD_SETTLE,      1'b1);
      // byte run, high nibble then low nibble
      6'd37: w = clnb_cw(NIB_HI,    4'h0, 1'b0, 1'b1, HOLD_PULSE,       1'b0);
      6'd38: w = clnb_cw(NIB_HI,    4'h0, 1'b1, 1'b1, HOLD_PULSE,       1'b0);
      6'd39: w = clnb_cw(NIB_HI,    4'h0, 1'b0, 1'b1, HOLD_SETTLE,      1'b0);
      6'd40: w = clnb_cw(NIB_LO,    4'h0, 1'b0, 1'b1, HOLD_PULSE,       1'b0);
      6'd41: w = clnb_cw(NIB_LO,    4'h0, 1'b1, 1'b1, HOLD_PULSE,       1'b0);
      6'd42: w = clnb_cw(NIB_LO,    4'h0, 1'b0, 1'b1, HOLD_SETTLE_COND, 1'b1);
      default: w = clnb_cw(NIB_HELD, 4'h0, 1'b0, 1'b0, HOLD_PULSE,      1'b1);
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/clnb_if.sv @@
// ----------------------------------------------------------------------------
// clnb_if
// Valid/ready channels for requests and pin states of the LCD sequencer.
// ----------------------------------------------------------------------------
interface clnb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic [7:0] column;
  logic [7:0] row;

  modport source (output valid, req_type, data_byte, column, row, input ready);
  modport sink   (input valid, req_type, data_byte, column, row, output ready);
endinterface

interface clnb_pin_if;
  logic        valid;
  logic        ready;
  logic        rs_level;
  logic        enable_level;
  logic [3:0]  data_nibble;
  logic [16:0] hold_us;
  logic        last;

  modport source (output valid, rs_level, enable_level, data_nibble, hold_us, last,
                  input ready);
  modport sink   (input valid, rs_level, enable_level, data_nibble, hold_us, last,
                  output ready);
endinterface

@@ rtl/core/clnb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// clnb_cfg_regs
// APB-style register file holding the timing and geometry settings.
// ----------------------------------------------------------------------------
module clnb_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [clnb_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [clnb_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [clnb_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output clnb_pkg::clnb_cfg_t               cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // register writes, masked to width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_pulse_us <= clnb_pkg::RST_ENABLE_PULSE;
      cfg.settle_us       <= clnb_pkg::RST_SETTLE;
      cfg.long_cmd_us     <= clnb_pkg::RST_LONG_CMD;
      cfg.power_wait_us   <= clnb_pkg::RST_POWER_WAIT;
      cfg.line_length     <= clnb_pkg::RST_LINE_LENGTH;
    end else if (wr_en) begin
      case (reg_idx)
        clnb_pkg::REG_ENABLE_PULSE: cfg.enable_pulse_us <= pwdata[7:0];
        clnb_pkg::REG_SETTLE:       cfg.settle_us       <= pwdata[9:0];
        clnb_pkg::REG_LONG_CMD:     cfg.long_cmd_us     <= pwdata[15:0];
        clnb_pkg::REG_POWER_WAIT:   cfg.power_wait_us   <= pwdata[15:0];
        clnb_pkg::REG_LINE_LENGTH:  cfg.line_length     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      clnb_pkg::REG_ENABLE_PULSE: prdata = {24'd0, cfg.enable_pulse_us};
      clnb_pkg::REG_SETTLE:       prdata = {22'd0, cfg.settle_us};
      clnb_pkg::REG_LONG_CMD:     prdata = {16'd0, cfg.long_cmd_us};
      clnb_pkg::REG_POWER_WAIT:   prdata = {16'd0, cfg.power_wait_us};
      clnb_pkg::REG_LINE_LENGTH:  prdata = {25'd0, cfg.line_length};
      default:                    prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/char_lcd_nibble_bus_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_bus_sequencer_unit
// Turns LCD requests into timed 4-bit bus pin states, one per cycle unless stalled.
// ----------------------------------------------------------------------------
// Start: a request transfer sets busy and the step counter; each step then registers
//   a pin state. Throughput: one pin state per cycle unless output stalls, set by
//   the microcode step counter; a byte request gives 6 states, init gives 37.
// Output back-pressure stalls the step counter; the last state may wait while idle.
// Reset (rst, synchronous): registers return to defaults, held nibble clears,
//   sequencer goes idle; no clearing pass.
module char_lcd_nibble_bus_sequencer_unit #(
  parameter int ROWS = clnb_pkg::ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  clnb_req_if.sink                        req,
  clnb_pin_if.source                      pin,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [clnb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [clnb_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [clnb_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam logic [1:0] ROW_MAX = 2'(ROWS - 1);

  clnb_pkg::clnb_cfg_t cfg;

  logic                      busy;
  logic [clnb_pkg::PC_W-1:0] pc;
  logic [7:0]                byte_q;
  logic                      rs_q;
  logic                      long_q;
  logic [3:0]                held_nibble;

  logic                      out_valid;
  logic                      out_rs;
  logic                      out_en;
  logic [3:0]                out_nib;
  logic [16:0]               out_hold;
  logic                      out_last;

  logic                      in_xfer;
  logic                      step;
  clnb_pkg::clnb_cw_t        cw;
  logic [3:0]                nib_next;
  logic [16:0]               hold_next;
  logic [15:0]               addend;
  logic [1:0]                row_c;
  logic [7:0]                row_off;
  logic [7:0]                byte_next;
  logic                      rs_next;
  logic                      long_next;

  clnb_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake
  assign req.ready = !busy;
  assign in_xfer   = req.valid && !busy;
  assign step      = busy && (!out_valid || pin.ready);

  assign pin.valid        = out_valid;
  assign pin.rs_level     = out_rs;
  assign pin.enable_level = out_en;
  assign pin.data_nibble  = out_nib;
  assign pin.hold_us      = out_hold;
  assign pin.last         = out_last;

  // request decode: byte to send, rs level, long wait flag
  always_comb begin
    row_c = (req.row > 8'd3) ? 2'd3 : req.row[1:0];
    if (row_c > ROW_MAX) begin
      row_c = ROW_MAX;
    end
    case (row_c)
      2'd0:    row_off = 8'd0;
      2'd1:    row_off = clnb_pkg::ROW1_BASE;
      2'd2:    row_off = {1'b0, cfg.line_length};
      default: row_off = clnb_pkg::ROW1_BASE + {1'b0, cfg.line_length};
    endcase
    byte_next = req.data_byte;
    rs_next   = 1'b0;
    long_next = 1'b0;
    case (req.req_type)
      clnb_pkg::REQ_CMD: begin
        long_next = (req.data_byte >= clnb_pkg::CMD_CLEAR) &&
                    (req.data_byte <= clnb_pkg::CMD_HOME_HI);
      end
      clnb_pkg::REQ_DATA: begin
        rs_next = 1'b1;
      end
      clnb_pkg::REQ_CURSOR: begin
        byte_next = clnb_pkg::CMD_SET_DDRAM | (req.column + row_off);
      end
      default: ;
    endcase
  end

  // control word fetch and datapath
  always_comb begin
    cw = clnb_pkg::clnb_ucode(pc);
    case (cw.nib_sel)
      clnb_pkg::NIB_CONST: nib_next = cw.nib;
      clnb_pkg::NIB_HELD:  nib_next = held_nibble;
      clnb_pkg::NIB_HI:    nib_next = byte_q[7:4];
      default:             nib_next = byte_q[3:0];
    endcase
    case (cw.hold_sel)
      clnb_pkg::HOLD_SETTLE_A:    addend = clnb_pkg::INIT_WAIT_A;
      clnb_pkg::HOLD_SETTLE_B:    addend = clnb_pkg::INIT_WAIT_B;
      clnb_pkg::HOLD_SETTLE_LONG: addend = cfg.long_cmd_us;
      clnb_pkg::HOLD_SETTLE_COND: addend = long_q ? cfg.long_cmd_us : 16'd0;
      default:                    addend = 16'd0;
    endcase
    case (cw.hold_sel)
      clnb_pkg::HOLD_POWER: hold_next = {1'b0, cfg.power_wait_us};
      clnb_pkg::HOLD_PULSE: hold_next = {9'd0, cfg.enable_pulse_us};
      default:              hold_next = {7'd0, cfg.settle_us} + {1'b0, addend};
    endcase
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pc          <= clnb_pkg::INIT_ENTRY;
      held_nibble <= 4'd0;
      out_valid   <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy <= 1'b1;
        pc   <= (req.req_type == clnb_pkg::REQ_INIT) ? clnb_pkg::INIT_ENTRY
                                                     : clnb_pkg::BYTE_ENTRY;
      end else if (step) begin
        pc <= pc + 1'b1;
        if (cw.last) begin
          busy <= 1'b0;
        end
      end
      if (step) begin
        out_valid   <= 1'b1;
        held_nibble <= nib_next;
      end else if (pin.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request payload capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_q <= byte_next;
      rs_q   <= rs_next;
      long_q <= long_next;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_rs   <= cw.use_rs & rs_q;
      out_en   <= cw.en;
      out_nib  <= nib_next;
      out_hold <= hold_next;
      out_last <= cw.last;
    end
  end

  // checks
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pc < clnb_pkg::PROG_END))
    else $error("microcode step out of range");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> busy)
    else $error("sequencer not started after request transfer");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (step && cw.last) |=> !busy)
    else $error("sequencer still running after its last state");

  a_start_needs_xfer: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(in_xfer))
    else $error("sequencer started without a request transfer");

endmodule
